[src/address_region_table_assert.svh]
// Assertion macros for the address region table RTL.
// Depends on a clk and an arst_n signal in the scope of each use.
`ifndef ADDRESS_REGION_TABLE_ASSERT_SVH
`define ADDRESS_REGION_TABLE_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define ART_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ART_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

[src/art_pkg.sv]
// Shared types, codes and defaults for the address region table.
// No dependencies; used by art_cell and address_region_table.
`default_nettype none

package art_pkg;

	localparam int REGIONS_DEF    = 32;
	localparam int PAGE_SHIFT_DEF = 12;

	localparam logic [31:0] WIN_BASE_RST = 32'h0020_0000;
	localparam logic [31:0] WIN_TOP_RST  = 32'hB000_0000;

	typedef enum logic [1:0] {
		FUNC_MAP    = 2'd0,
		FUNC_LOOKUP = 2'd1,
		FUNC_CHECK  = 2'd2,
		FUNC_CLEAR  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_BAD  = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	localparam int FLAG_READ_BIT  = 0;
	localparam int FLAG_WRITE_BIT = 1;
	localparam int FLAG_STACK_BIT = 3;

	typedef enum logic [0:0] {
		REG_WIN_BASE = 1'b0,
		REG_WIN_TOP  = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [31:0] addr;
		logic [31:0] length;
		logic [3:0]  perm_flags;
		logic        want_write;
	} req_beat_t;

	typedef struct packed {
		logic [1:0]  status;
		logic        hit;
		logic [31:0] region_base;
		logic [31:0] region_limit;
		logic [3:0]  region_perm;
		logic [5:0]  region_total;
	} rsp_beat_t;

	typedef struct packed {
		logic [31:0] start;
		logic [31:0] limit;
		logic [3:0]  flags;
	} entry_t;

	// Data passed from one cell to its right neighbor.
	typedef struct packed {
		logic   valid;
		logic   le;
		entry_t ent;
	} link_t;

	// Compare results of one cell against the current probe.
	typedef struct packed {
		logic le;
		logic match;
		logic ov;
	} cell_stat_t;

endpackage

`default_nettype wire

[src/art_cell.sv]
// One table cell: holds a region and compares it against the probe address.
// Depends on art_pkg; instanced in a row by address_region_table.
`default_nettype none

module art_cell #(
	parameter int INDEX = 0,
	parameter int CW    = 6
) (
	input  wire               clk,
	input  wire  [CW-1:0]     count,
	input  wire  [31:0]       probe,
	input  art_pkg::entry_t   ins_ent,
	input  wire               ins_en,
	input  art_pkg::link_t    left,
	output art_pkg::link_t    right,
	output art_pkg::cell_stat_t stat
);

	art_pkg::entry_t ent_q;
	logic valid;
	logic le;

	assign valid = count > CW'(INDEX);
	assign le    = valid && (ent_q.start <= probe);

	// Compare against probe and against the range being inserted
	assign stat.le    = le;
	assign stat.match = le && (probe < ent_q.limit);
	assign stat.ov    = valid && (ent_q.start > probe) && (ent_q.start < ins_ent.limit);

	assign right.valid = valid;
	assign right.le    = le;
	assign right.ent   = ent_q;

	// Take the new region at the insert point, shift from the left above it
	always_ff @(posedge clk) begin
		if (ins_en) begin
			if (left.le && !le) begin
				ent_q <= ins_ent;
			end else if (left.valid && !left.le) begin
				ent_q <= left.ent;
			end
		end
	end

endmodule

`default_nettype wire

[src/address_region_table.sv]
// Top level of the address region table: APB registers, sequencer, cell row.
// Depends on art_pkg, art_cell and address_region_table_assert.svh.
`default_nettype none

// Address region table. Regions live in a row of REGIONS cells kept sorted by
// start address; every cell compares its region with the probe address in
// parallel. One request is in work at a time. Lookup, clear and map go from
// accept through the probe, pick, decide and out states to the result; a map
// insert shifts the whole row at once. A check walks the span one region
// per pass through the probe, pick and decide states, up to REGIONS regions. A
// result waits in an output register; the next request is accepted meanwhile.
// Window registers: offset 0 user_window_base, offset 4 user_window_top.
// There is no clearing pass after reset.
module address_region_table #(
	parameter int REGIONS    = art_pkg::REGIONS_DEF,
	parameter int PAGE_SHIFT = art_pkg::PAGE_SHIFT_DEF
) (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 psel,
	input  wire                 penable,
	input  wire                 pwrite,
	input  wire  [2:0]          paddr,
	input  wire  [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,
	input  wire                 req_valid,
	output logic                req_stall,
	input  art_pkg::req_beat_t  req,
	output logic                rsp_valid,
	input  wire                 rsp_stall,
	output art_pkg::rsp_beat_t  rsp
);

	localparam int CW = $clog2(REGIONS + 1);
	localparam int HW = $clog2(REGIONS);
	localparam logic [33:0] PMASK = (34'd1 << PAGE_SHIFT) - 34'd1;
	localparam logic [32:0] PSIZE = 33'd1 << PAGE_SHIFT;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_PROBE  = 5'b00010,
		ST_PICK   = 5'b00100,
		ST_DECIDE = 5'b01000,
		ST_OUT    = 5'b10000
	} state_t;

	state_t state_q;
	logic [31:0] win_base_q, win_top_q;
	logic [1:0]  func_q;
	logic        wr_q;
	logic [3:0]  perm_q;
	logic [31:0] probe_q;
	logic [31:0] lim_q;
	logic        bad_q;
	logic [CW-1:0] count_q;
	logic [HW-1:0] hint_q;
	logic        hint_v_q;
	logic [REGIONS-1:0] match_q, le_q, ov_q;
	logic        hit_q;
	logic [HW-1:0] kidx_q;
	art_pkg::entry_t kent_q;
	art_pkg::rsp_beat_t res_q;
	logic        rsp_valid_q;
	art_pkg::rsp_beat_t rsp_q;

	// APB register port
	assign pready = 1'b1;
	always_comb begin
		unique case (art_pkg::reg_idx_t'(paddr[2]))
			art_pkg::REG_WIN_BASE: prdata = win_base_q;
			art_pkg::REG_WIN_TOP:  prdata = win_top_q;
			default:               prdata = win_base_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_base_q <= art_pkg::WIN_BASE_RST;
			win_top_q  <= art_pkg::WIN_TOP_RST;
		end else if (psel && penable && pwrite) begin
			if (art_pkg::reg_idx_t'(paddr[2]) == art_pkg::REG_WIN_TOP) begin
				win_top_q <= pwdata;
			end else begin
				win_base_q <= pwdata;
			end
		end
	end

	// Request decode: page rounding, overflow and window checks
	logic        req_acc;
	logic [33:0] sum34, rnd34;
	logic [31:0] map_s;
	logic        map_bad, chk_bad;

	assign req_stall = (state_q != ST_IDLE);
	assign req_acc   = req_valid && !req_stall;

	always_comb begin
		sum34   = {2'b00, req.addr} + {2'b00, req.length};
		rnd34   = (sum34 + PMASK) & ~PMASK;
		map_s   = req.addr & ~PMASK[31:0];
		map_bad = sum34[32] || (rnd34[33:32] != 2'b00) ||
			!((win_base_q <= map_s) && (map_s < rnd34[31:0]) && (rnd34[31:0] <= win_top_q));
		chk_bad = sum34[32] ||
			!((win_base_q <= req.addr) && (req.addr < sum34[31:0]) &&
			(sum34[31:0] <= win_top_q));
	end

	// Cell row
	art_pkg::link_t      links [REGIONS+1];
	art_pkg::cell_stat_t stats [REGIONS];
	art_pkg::entry_t     ins_ent;
	logic                ins_en;

	assign ins_ent.start = probe_q;
	assign ins_ent.limit = lim_q;
	assign ins_ent.flags = perm_q;

	assign links[0].valid = 1'b0;
	assign links[0].le    = 1'b1;
	assign links[0].ent   = '0;

	for (genvar i = 0; i < REGIONS; i++) begin : g_cell
		art_cell #(.INDEX(i), .CW(CW)) u_cell (
			.clk     (clk),
			.count   (count_q),
			.probe   (probe_q),
			.ins_ent (ins_ent),
			.ins_en  (ins_en),
			.left    (links[i]),
			.right   (links[i+1]),
			.stat    (stats[i])
		);
	end

	// Select the single matching cell
	art_pkg::entry_t pick_ent;
	logic [HW-1:0]   pick_idx;
	always_comb begin
		pick_ent = '0;
		pick_idx = '0;
		for (int i = 0; i < REGIONS; i++) begin
			if (match_q[i]) begin
				pick_ent = pick_ent | links[i+1].ent;
				pick_idx = pick_idx | HW'(i);
			end
		end
	end

	// Decide one pass
	logic        full, ov_any, map_ok, guard, perm_ok, walk_done;
	logic [32:0] guard_lim;
	always_comb begin
		full      = (count_q == CW'(REGIONS));
		ov_any    = |ov_q;
		map_ok    = !bad_q && !hit_q && !full && !ov_any;
		guard_lim = {1'b0, kent_q.start} + PSIZE;
		guard     = wr_q && kent_q.flags[art_pkg::FLAG_STACK_BIT] &&
			({1'b0, probe_q} < guard_lim);
		perm_ok   = wr_q ? kent_q.flags[art_pkg::FLAG_WRITE_BIT]
			: kent_q.flags[art_pkg::FLAG_READ_BIT];
		walk_done = kent_q.limit >= lim_q;
		ins_en    = (state_q == ST_DECIDE) && (func_q == art_pkg::FUNC_MAP) && map_ok;
	end

	// Build the result of one pass and the outgoing beat
	art_pkg::rsp_beat_t res_d, rsp_d;
	always_comb begin
		res_d = '0;
		if (state_q == ST_DECIDE) begin
			unique case (art_pkg::func_t'(func_q))
				art_pkg::FUNC_MAP: begin
					if (bad_q || hit_q) begin
						res_d.status = art_pkg::STAT_BAD;
					end else if (full) begin
						res_d.status = art_pkg::STAT_FULL;
					end else if (ov_any) begin
						res_d.status = art_pkg::STAT_BAD;
					end else begin
						res_d.region_base  = probe_q;
						res_d.region_limit = lim_q;
						res_d.region_perm  = perm_q;
					end
				end
				art_pkg::FUNC_LOOKUP: begin
					if (hit_q) begin
						res_d.hit          = 1'b1;
						res_d.region_base  = kent_q.start;
						res_d.region_limit = kent_q.limit;
						res_d.region_perm  = kent_q.flags;
					end
				end
				art_pkg::FUNC_CHECK: begin
					if (!bad_q && hit_q && perm_ok && !guard) begin
						res_d.hit = 1'b1;
					end else begin
						res_d.status = art_pkg::STAT_BAD;
					end
				end
				art_pkg::FUNC_CLEAR: ;
				default: ;
			endcase
		end
		rsp_d              = res_q;
		rsp_d.region_total = 6'(count_q);
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			hint_q      <= '0;
			hint_v_q    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: state_q <= ST_PICK;
				ST_PICK:  state_q <= ST_DECIDE;
				ST_DECIDE: begin
					state_q <= ST_OUT;
					unique case (art_pkg::func_t'(func_q))
						art_pkg::FUNC_MAP: begin
							if (!bad_q && hit_q) begin
								hint_q   <= kidx_q;
								hint_v_q <= 1'b1;
							end else if (map_ok) begin
								count_q <= count_q + CW'(1);
								if (hint_v_q && !le_q[hint_q]) begin
									hint_q <= hint_q + HW'(1);
								end
							end
						end
						art_pkg::FUNC_LOOKUP: begin
							if (hit_q) begin
								hint_q   <= kidx_q;
								hint_v_q <= 1'b1;
							end
						end
						art_pkg::FUNC_CHECK: begin
							if (!bad_q && hit_q) begin
								hint_q   <= kidx_q;
								hint_v_q <= 1'b1;
							end
							if (!bad_q && hit_q && perm_ok && !guard && !walk_done) begin
								state_q <= ST_PROBE;
							end
						end
						art_pkg::FUNC_CLEAR: begin
							count_q  <= '0;
							hint_q   <= '0;
							hint_v_q <= 1'b0;
						end
						default: ;
					endcase
				end
				ST_OUT: begin
					if (!rsp_valid_q || !rsp_stall) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			// Load a new beat when the output register is free, drop a taken one
			if (state_q == ST_OUT && (!rsp_valid_q || !rsp_stall)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (req_acc) begin
			func_q <= req.func;
			wr_q   <= req.want_write;
			perm_q <= req.perm_flags;
			if (art_pkg::func_t'(req.func) == art_pkg::FUNC_MAP) begin
				probe_q <= map_s;
				lim_q   <= rnd34[31:0];
				bad_q   <= map_bad;
			end else begin
				probe_q <= req.addr;
				lim_q   <= sum34[31:0];
				bad_q   <= chk_bad;
			end
		end
		if (state_q == ST_PROBE) begin
			for (int i = 0; i < REGIONS; i++) begin
				match_q[i] <= stats[i].match;
				le_q[i]    <= stats[i].le;
				ov_q[i]    <= stats[i].ov;
			end
		end
		if (state_q == ST_PICK) begin
			hit_q  <= |match_q;
			kidx_q <= pick_idx;
			kent_q <= pick_ent;
		end
		if (state_q == ST_DECIDE) begin
			res_q <= res_d;
			if (art_pkg::func_t'(func_q) == art_pkg::FUNC_CHECK &&
				!bad_q && hit_q && perm_ok && !guard && !walk_done) begin
				probe_q <= kent_q.limit;
			end
		end
		if (state_q == ST_OUT && (!rsp_valid_q || !rsp_stall)) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`include "address_region_table_assert.svh"

	`ART_ASSERT_NOW(a_hint_in_table, hint_v_q, CW'(hint_q) < count_q, "hint beyond table")
	`ART_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CW'(REGIONS), "count above depth")
	`ART_ASSERT_NEXT(a_accept_busy, req_acc, state_q == ST_PROBE, "accept did not start probe")
	`ART_ASSERT_NOW(a_insert_room, ins_en, count_q < CW'(REGIONS), "insert into full table")

endmodule

`default_nettype wire

[tb/address_region_table_tb.sv]
// Self-checking testbench for address_region_table: map, lookup, check, clear.
// Depends on art_pkg and the address_region_table RTL; a scoreboard class predicts each beat.
`timescale 1ns / 100ps

module address_region_table_tb;
	import art_pkg::*;

	localparam int unsigned PAGE = 1 << PAGE_SHIFT_DEF;
	localparam int NREG = REGIONS_DEF;
	localparam logic [63:0] MASK32 = 64'hFFFF_FFFF;

	// Region table predictor with a queue of expected response beats.
	class region_scoreboard;
		logic [31:0] win_base, win_top;
		logic [31:0] starts [NREG];
		logic [31:0] ends [NREG];
		logic [3:0]  flags [NREG];
		int          count, hint;
		bit          hint_ok;
		rsp_beat_t   answers [$];
		int          errors;

		function new();
			win_base = WIN_BASE_RST;
			win_top  = WIN_TOP_RST;
			count    = 0;
			hint     = 0;
			hint_ok  = 0;
			errors   = 0;
		endfunction

		function void set_window(reg_idx_t idx, logic [31:0] val);
			if (idx == REG_WIN_BASE)
				win_base = val;
			else
				win_top = val;
		endfunction

		function bit in_window(logic [63:0] s, logic [63:0] e);
			return {32'b0, win_base} <= s && s < e && e <= {32'b0, win_top};
		endfunction

		// Return the index of the region holding a, or -1; refresh the hint on a scan hit.
		function int find_region(logic [31:0] a);
			if (hint_ok && hint < count && starts[hint] <= a && a < ends[hint])
				return hint;
			for (int i = 0; i < count; i++) begin
				if (starts[i] <= a && a < ends[i]) begin
					hint    = i;
					hint_ok = 1;
					return i;
				end
			end
			return -1;
		endfunction

		function void note_request(req_beat_t b);
			rsp_beat_t   r;
			logic [63:0] pm, s, e;
			logic [3:0]  need;
			int          pos, k, steps;
			bit          ok;
			r  = '0;
			pm = PAGE - 1;
			case (func_t'(b.func))
				FUNC_MAP: begin
					s = {32'b0, b.addr} & ~pm;
					e = {32'b0, b.addr} + {32'b0, b.length};
					r.status = STAT_OK;
					if (e > MASK32 || ((e + pm) & ~pm) > MASK32) begin
						r.status = STAT_BAD;
					end else begin
						e = (e + pm) & ~pm;
						if (!in_window(s, e) || find_region(s[31:0]) >= 0) begin
							r.status = STAT_BAD;
						end else if (count >= NREG) begin
							r.status = STAT_FULL;
						end else begin
							pos = 0;
							while (pos < count && {32'b0, starts[pos]} <= s)
								pos++;
							if ((pos > 0 && {32'b0, ends[pos-1]} > s) ||
									(pos < count && e > {32'b0, starts[pos]})) begin
								r.status = STAT_BAD;
							end else begin
								// shift the upper entries to open a slot
								for (int i = count; i > pos; i--) begin
									starts[i] = starts[i-1];
									ends[i]   = ends[i-1];
									flags[i]  = flags[i-1];
								end
								starts[pos] = s[31:0];
								ends[pos]   = e[31:0];
								flags[pos]  = b.perm_flags;
								count++;
								if (hint_ok && hint >= pos)
									hint++;
								r.region_base  = s[31:0];
								r.region_limit = e[31:0];
								r.region_perm  = b.perm_flags;
							end
						end
					end
				end
				FUNC_LOOKUP: begin
					k = find_region(b.addr);
					r.status = STAT_OK;
					if (k >= 0) begin
						r.hit          = 1'b1;
						r.region_base  = starts[k];
						r.region_limit = ends[k];
						r.region_perm  = flags[k];
					end
				end
				FUNC_CHECK: begin
					e     = {32'b0, b.addr} + {32'b0, b.length};
					ok    = e <= MASK32 && in_window({32'b0, b.addr}, e);
					s     = {32'b0, b.addr};
					steps = 0;
					need  = b.want_write ? (4'b1 << FLAG_WRITE_BIT) : (4'b1 << FLAG_READ_BIT);
					// walk adjacent regions across the span
					while (ok && s < e) begin
						if (steps > NREG) begin
							ok = 0;
							break;
						end
						steps++;
						k = find_region(s[31:0]);
						if (k < 0 || (flags[k] & need) == 0) begin
							ok = 0;
							break;
						end
						if (b.want_write && flags[k][FLAG_STACK_BIT] &&
								s < {32'b0, starts[k]} + PAGE) begin
							ok = 0;
							break;
						end
						s = {32'b0, ends[k]};
					end
					r.status = ok ? STAT_OK : STAT_BAD;
					r.hit    = ok;
				end
				default: begin
					count   = 0;
					hint    = 0;
					hint_ok = 0;
					r.status = STAT_OK;
				end
			endcase
			r.region_total = count[5:0];
			answers.push_back(r);
		endfunction

		function void check_result(rsp_beat_t got);
			rsp_beat_t x;
			if (answers.size() == 0) begin
				$error("unexpected response beat %h", got);
				errors++;
				return;
			end
			x = answers.pop_front();
			if (got.status !== x.status) begin
				$error("status: expected %h actual %h", x.status, got.status);
				errors++;
			end
			if (got.hit !== x.hit) begin
				$error("hit: expected %h actual %h", x.hit, got.hit);
				errors++;
			end
			if (got.region_base !== x.region_base) begin
				$error("region_base: expected %h actual %h", x.region_base, got.region_base);
				errors++;
			end
			if (got.region_limit !== x.region_limit) begin
				$error("region_limit: expected %h actual %h", x.region_limit, got.region_limit);
				errors++;
			end
			if (got.region_perm !== x.region_perm) begin
				$error("region_perm: expected %h actual %h", x.region_perm, got.region_perm);
				errors++;
			end
			if (got.region_total !== x.region_total) begin
				$error("region_total: expected %h actual %h", x.region_total, got.region_total);
				errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid;
	logic        req_stall;
	req_beat_t   req;
	logic        rsp_valid;
	logic        rsp_stall;
	rsp_beat_t   rsp;

	region_scoreboard board;
	bit          calm;
	bit          long_hold;
	logic [31:0] pool;

	address_region_table i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Abort a hung run.
	initial begin
		#10_000_000;
		$display("tb: failure");
		$finish;
	end

	// Drain responses with random stalls and an occasional long hold.
	initial begin : rsp_side
		int stall_left;
		stall_left = 0;
		rsp_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				board.check_result(rsp);
				stall_left = calm ? 0 : $urandom_range(0, 9);
			end else if (stall_left > 0) begin
				stall_left--;
			end
			if (long_hold) begin
				long_hold  = 0;
				stall_left = 300;
			end
			rsp_stall <= (stall_left > 0);
		end
	end

	// Offer one request beat and hold it until accepted.
	task automatic send(logic [1:0] f, logic [31:0] a, logic [31:0] len,
			logic [3:0] perm, logic wr);
		req_beat_t b;
		int gap;
		b   = '{func: f, addr: a, length: len, perm_flags: perm, want_write: wr};
		gap = calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= b;
		@(posedge clk);
		while (req_stall) @(posedge clk);
		board.note_request(b);
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		while (board.answers.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	// Write one window register through a setup and an access cycle.
	task automatic write_window(reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= 3'(idx) << 2;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.set_window(idx, val);
	endtask

	// One random request, mostly clustered around the pool so regions collide.
	task automatic random_beat();
		logic [31:0] a, len;
		int pick;
		pick = $urandom_range(0, 99);
		a    = pool + $urandom_range(0, 47) * PAGE;
		if ($urandom_range(0, 1))
			a = a + $urandom_range(0, PAGE - 1);
		len = $urandom_range(0, 19) == 0 ? 0 : $urandom_range(1, 4 * PAGE);
		if (pick < 35)
			send(FUNC_MAP, a, len, 4'($urandom), 1'($urandom));
		else if (pick < 60)
			send(FUNC_LOOKUP, a, len, 4'($urandom), 1'($urandom));
		else if (pick < 95)
			send(FUNC_CHECK, a, len, 4'($urandom), 1'($urandom));
		else if (pick < 97)
			send(FUNC_CLEAR, a, len, 4'($urandom), 1'($urandom));
		else
			send(2'($urandom), $urandom, $urandom, 4'($urandom), 1'($urandom));
	endtask

	// Random stretch with calm spells and a periodic fill past capacity.
	task automatic random_phase(int n, int hold_at);
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0)
				calm = ($urandom_range(0, 3) == 0);
			if (i == hold_at)
				long_hold = 1;
			if (i % 300 == 150) begin
				send(FUNC_CLEAR, 0, 0, 0, 0);
				for (int j = 0; j < NREG + 2; j++)
					send(FUNC_MAP, pool + j * PAGE, PAGE, 4'($urandom), 1'($urandom));
			end
			random_beat();
		end
	endtask

	initial begin
		board     = new();
		calm      = 0;
		long_hold = 0;
		arst_n    = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = '0;
		pwdata    = '0;
		req_valid = 1'b0;
		req       = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: mapping, overlaps, overflow, window, permissions, stack guard
		pool = WIN_BASE_RST;
		send(FUNC_LOOKUP, pool, 0, 0, 0);
		send(FUNC_MAP, pool, 1, 4'b0011, 0);
		send(FUNC_MAP, pool + 32'h2000, 32'h1800, 4'b1011, 1);
		send(FUNC_MAP, pool + 32'h1000, 32'h1000, 4'b0100, 0);
		send(FUNC_MAP, pool + 32'h0800, 4, 4'b1111, 0);
		send(FUNC_MAP, pool + 32'h5000, 32'h1000, 4'b0001, 0);
		send(FUNC_MAP, pool + 32'h4000, 32'h2000, 4'b0001, 0);
		send(FUNC_MAP, pool + 32'h9000, 0, 4'b0001, 0);
		send(FUNC_MAP, 32'hFFFF_F800, 32'h1000, 4'b0001, 0);
		send(FUNC_MAP, 32'hFFFF_F800, 32'h100, 4'b0001, 0);
		send(FUNC_MAP, 32'h0010_0000, 32'h1000, 4'b0001, 0);
		send(FUNC_MAP, 32'hAFFF_F000, 32'h2000, 4'b0001, 0);
		send(FUNC_LOOKUP, pool + 32'h2800, 0, 0, 0);
		send(FUNC_LOOKUP, pool + 32'h1000, 0, 0, 1);
		send(FUNC_CHECK, pool, 32'h1000, 0, 0);
		send(FUNC_CHECK, pool, 32'h3000, 0, 0);
		send(FUNC_CHECK, pool + 32'h2000, 32'h10, 0, 1);
		send(FUNC_CHECK, pool + 32'h3000, 32'h100, 0, 1);
		send(FUNC_CHECK, pool, 32'h2000, 0, 1);
		send(FUNC_CHECK, 32'hFFFF_FFF0, 32'h20, 0, 0);
		send(FUNC_CHECK, pool, 0, 0, 0);
		send(FUNC_LOOKUP, 32'h0, 32'hFFFF_FFFF, 4'hF, 1);
		send(FUNC_LOOKUP, 32'hFFFF_FFFF, 0, 0, 0);
		send(FUNC_CLEAR, 0, 0, 0, 0);
		send(FUNC_LOOKUP, pool, 0, 0, 0);

		random_phase(400, 100);

		// widest window
		drain();
		write_window(REG_WIN_BASE, 32'h0);
		write_window(REG_WIN_TOP, 32'hFFFF_FFFF);
		pool = 32'hFFFC_0000;
		random_phase(350, -1);

		// inverted window: nothing fits
		drain();
		write_window(REG_WIN_BASE, 32'hFFFF_FFFF);
		write_window(REG_WIN_TOP, 32'h0);
		random_phase(60, -1);

		// narrow window of 64 pages
		drain();
		write_window(REG_WIN_BASE, 32'h1000_0000);
		write_window(REG_WIN_TOP, 32'h1004_0000);
		pool = 32'h1000_0000;
		random_phase(400, -1);

		drain();
		if (board.errors == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
